[rtl/bgc_pkg.sv]
// ----------------------------------------------------------------------------
// Button gesture classifier package
// Shared transaction types, signal codes and button pattern codes.
// ----------------------------------------------------------------------------
package bgc_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned BtnW     = 3;
  localparam int unsigned DispW    = 2;
  localparam int unsigned CodeW    = 4;
  localparam int unsigned SimulW   = 12;
  localparam int unsigned HoldW    = 14;
  localparam int unsigned ElapsedW = 14;

  // Register reset values.
  localparam logic [SimulW-1:0] SIMUL_RESET = 12'd200;
  localparam logic [HoldW-1:0]  HOLD_RESET  = 14'd2000;

  // Result signal codes.
  localparam logic [CodeW-1:0] SIG_NONE      = 4'd0;
  localparam logic [CodeW-1:0] SIG_MODE_REL  = 4'd1;
  localparam logic [CodeW-1:0] SIG_ALL_HELD  = 4'd2;
  localparam logic [CodeW-1:0] SIG_MODE      = 4'd3;
  localparam logic [CodeW-1:0] SIG_MODE_HELD = 4'd4;
  localparam logic [CodeW-1:0] SIG_SET       = 4'd5;
  localparam logic [CodeW-1:0] SIG_CALC_MODE = 4'd6;
  localparam logic [CodeW-1:0] SIG_TIRE_CIRC = 4'd7;
  localparam logic [CodeW-1:0] SIG_START     = 4'd8;
  localparam logic [CodeW-1:0] SIG_STOP      = 4'd9;
  localparam logic [CodeW-1:0] SIG_MS_HELD   = 4'd10;

  // Button patterns: bit0 mode, bit1 set, bit2 start/stop.
  localparam logic [BtnW-1:0] PAT_NONE       = 3'b000;
  localparam logic [BtnW-1:0] PAT_MODE       = 3'b001;
  localparam logic [BtnW-1:0] PAT_SET        = 3'b010;
  localparam logic [BtnW-1:0] PAT_START      = 3'b100;
  localparam logic [BtnW-1:0] PAT_MODE_START = 3'b101;
  localparam logic [BtnW-1:0] PAT_ALL        = 3'b111;

  // Display mode and view codes.
  localparam logic [DispW-1:0] DMODE_DATA  = 2'd0;
  localparam logic [DispW-1:0] DMODE_UNITS = 2'd1;
  localparam logic [DispW-1:0] DMODE_CIRC  = 2'd2;
  localparam logic [DispW-1:0] VIEW_DIST   = 2'd0;
  localparam logic [DispW-1:0] VIEW_TIME   = 2'd1;
  localparam logic [DispW-1:0] VIEW_SPEED  = 2'd2;

  // Register indexes on the configuration port.
  localparam logic REG_SIMUL = 1'b0;
  localparam logic REG_HOLD  = 1'b1;

  // Input transaction: one timer tick.
  typedef struct packed {
    logic [BtnW-1:0]  buttons;
    logic [DispW-1:0] display_mode;
    logic [DispW-1:0] display_view;
  } in_t;

  // Output transaction: one classification result.
  typedef struct packed {
    logic [CodeW-1:0] signal_code;
    logic             toggle_units;
    logic             cycle_circumference;
    logic             reset_trip;
  } out_t;

endpackage

[rtl/button_gesture_classifier.sv]
// ----------------------------------------------------------------------------
// Button gesture classifier
// Classifies press, hold and combination gestures on a three-button panel.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transaction is one timer tick carrying the button sample and
//   the display mode and view. A classification opens on a tick, samples
//   through the window up to tick index simul_ticks (counting from zero) and,
//   for the hold patterns, watches the buttons until hold_ticks. It yields
//   exactly one output transaction; the ticks before it yield none.
//   The result of a tick is loaded into the output register on acceptance.
//   Throughput: one tick per cycle while the receiver takes results; the
//   classifier state and the output register update in the same cycle as
//   the tick is accepted. A tick is accepted whenever the output register
//   is empty or is being drained in the same cycle. When the receiver stalls
//   with a result pending, in_ready drops until that result is taken.
//   Reset clears the classifier state, the output register and restores
//   simul_ticks to 200 and hold_ticks to 2000. Registers are written through
//   the APB port at byte addresses 0 and 4. The user must write them only
//   while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module button_gesture_classifier (
  input  logic                clk,
  input  logic                rst,
  // Tick channel
  input  logic                in_valid,
  output logic                in_ready,
  input  bgc_pkg::in_t        in_data,
  // Result channel
  output logic                out_valid,
  input  logic                out_ready,
  output bgc_pkg::out_t       out_data,
  // Configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import bgc_pkg::*;

  // Classifier phases.
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_WINDOW = 2'd1;
  localparam logic [1:0] PH_HOLD   = 2'd2;

  logic [SimulW-1:0]   simul_ticks;
  logic [HoldW-1:0]    hold_ticks;
  logic [1:0]          phase;
  logic [1:0]          phase_next;
  logic [ElapsedW-1:0] elapsed_ticks;
  logic [ElapsedW-1:0] elapsed_ticks_next;
  logic [BtnW-1:0]     pattern;
  logic [BtnW-1:0]     pattern_next;
  logic [CodeW-1:0]    previous_signal;
  logic                running;
  logic                running_next;
  logic                emit;
  out_t                result;
  logic                in_accept;
  logic                cfg_write;

  // Configuration port: zero wait states, word index in paddr[2].
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      simul_ticks <= SIMUL_RESET;
      hold_ticks  <= HOLD_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_HOLD) begin
        hold_ticks <= pwdata[HoldW-1:0];
      end else begin
        simul_ticks <= pwdata[SimulW-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_SIMUL) begin
      prdata = {{(32-SimulW){1'b0}}, simul_ticks};
    end else begin
      prdata = {{(32-HoldW){1'b0}}, hold_ticks};
    end
  end

  // A tick is taken when the output register is free or drains this cycle.
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  // Classification of the current tick against the stored state.
  always_comb begin
    phase_next         = phase;
    pattern_next       = pattern;
    running_next       = running;
    emit               = 1'b0;
    result             = '0;
    result.signal_code = previous_signal;

    // Tick index within the classification, saturating.
    if (phase == PH_IDLE) begin
      elapsed_ticks_next = '0;
    end else if (elapsed_ticks != {ElapsedW{1'b1}}) begin
      elapsed_ticks_next = elapsed_ticks + 1'b1;
    end else begin
      elapsed_ticks_next = elapsed_ticks;
    end

    if (phase != PH_HOLD) begin
      // Sampling window: the last sample becomes the pattern.
      pattern_next = in_data.buttons;
      phase_next   = PH_WINDOW;
      if (elapsed_ticks_next >= {{(ElapsedW-SimulW){1'b0}}, simul_ticks}) begin
        emit = 1'b1;
        case (in_data.buttons)
          PAT_NONE: begin
            if (previous_signal == SIG_MODE || previous_signal == SIG_MODE_HELD) begin
              result.signal_code = SIG_MODE_REL;
            end else begin
              result.signal_code = SIG_NONE;
            end
          end
          PAT_SET: begin
            case (in_data.display_view)
              VIEW_DIST, VIEW_TIME: result.signal_code = SIG_CALC_MODE;
              VIEW_SPEED:           result.signal_code = SIG_TIRE_CIRC;
              default:              result.signal_code = SIG_SET;
            endcase
          end
          PAT_START: begin
            running_next       = !running;
            result.signal_code = running ? SIG_STOP : SIG_START;
          end
          PAT_ALL, PAT_MODE_START, PAT_MODE: begin
            // Enter the hold watch unless its window is already over.
            if (hold_ticks > elapsed_ticks_next) begin
              emit       = 1'b0;
              phase_next = PH_HOLD;
            end
          end
          default: begin
            result.signal_code = previous_signal;
          end
        endcase
      end
    end else begin
      // Hold watch: a change ends it early, the timeout gives the held result.
      if (in_data.buttons != pattern) begin
        emit = 1'b1;
        if (pattern == PAT_MODE) begin
          result.signal_code         = SIG_MODE;
          result.toggle_units        = (in_data.display_mode == DMODE_UNITS);
          result.cycle_circumference = (in_data.display_mode == DMODE_CIRC);
        end else begin
          result.signal_code = SIG_NONE;
        end
      end else if (elapsed_ticks_next >= hold_ticks) begin
        emit = 1'b1;
        case (pattern)
          PAT_ALL:  result.signal_code = SIG_ALL_HELD;
          PAT_MODE: result.signal_code = SIG_MODE_HELD;
          default: begin
            result.signal_code = SIG_MS_HELD;
            result.reset_trip  = (in_data.display_mode == DMODE_DATA);
          end
        endcase
      end
    end

    if (emit) begin
      phase_next = PH_IDLE;
    end
  end

  // Classifier state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      elapsed_ticks   <= '0;
      pattern         <= PAT_NONE;
      previous_signal <= SIG_NONE;
      running         <= 1'b0;
    end else if (in_accept) begin
      phase         <= phase_next;
      elapsed_ticks <= elapsed_ticks_next;
      pattern       <= pattern_next;
      running       <= running_next;
      if (emit) begin
        previous_signal <= result.signal_code;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      out_data <= result;
    end
  end

  // A trip reset request only travels with the mode+start/stop held result.
  a_trip_code : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.reset_trip |-> out_data.signal_code == SIG_MS_HELD)
    else $error("reset_trip without mode+start held code");

  // Units and circumference requests only travel with the mode result.
  a_mode_req : assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.toggle_units || out_data.cycle_circumference)
      |-> out_data.signal_code == SIG_MODE
          && !(out_data.toggle_units && out_data.cycle_circumference))
    else $error("mode request with wrong code or both requests");

  // Every emitted result closes the classification.
  a_emit_idle : assert property (@(posedge clk) disable iff (rst)
    in_accept && emit |=> phase == PH_IDLE && out_valid)
    else $error("classification not closed after result");

  // The hold watch only runs on a hold pattern.
  a_hold_pat : assert property (@(posedge clk) disable iff (rst)
    phase == PH_HOLD |-> pattern == PAT_ALL || pattern == PAT_MODE
                         || pattern == PAT_MODE_START)
    else $error("hold watch on a non-hold pattern");

  // The run flag follows the start and stop results.
  a_running : assert property (@(posedge clk) disable iff (rst)
    in_accept && emit && (result.signal_code == SIG_START
                          || result.signal_code == SIG_STOP)
      |=> running == (out_data.signal_code == SIG_START))
    else $error("run flag does not follow start/stop");

endmodule

[verif/tb_button_gesture_classifier.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Button gesture classifier testbench
// Sends timer ticks over valid/ready and programs the window and hold
// registers over APB. Every result is checked field by field against a
// scripted value or a behavioral predictor of the classifier beside the design.
// ----------------------------------------------------------------------------
module tb_button_gesture_classifier;
  import bgc_pkg::*;

  localparam int unsigned CycleLimit = 5_000_000;

  // Display codes that the package leaves unnamed.
  localparam logic [DispW-1:0] DMODE_OTHER = 2'd3;
  localparam logic [DispW-1:0] VIEW_OTHER  = 2'd3;
  localparam logic [2:0]       NoReq       = 3'b000;

  typedef enum logic [1:0] {CLS_IDLE, CLS_WINDOW, CLS_HOLD} cls_phase_e;
  typedef enum logic [1:0] {ROW_TICK, ROW_SIMUL, ROW_HOLD} row_kind_e;

  // One line of the directed script: a register write or a tick.
  typedef struct packed {
    row_kind_e   kind;
    logic [13:0] value;
    in_t         tick;
    logic        typed;
    out_t        want;
  } row_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_t         in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state and its copy of the registers.
  logic [SimulW-1:0]   cfg_simul    = SIMUL_RESET;
  logic [HoldW-1:0]    cfg_hold     = HOLD_RESET;
  cls_phase_e          cls_phase    = CLS_IDLE;
  logic [ElapsedW-1:0] elapsed      = '0;
  logic [BtnW-1:0]     held_pattern = '0;
  logic [CodeW-1:0]    prev_signal  = SIG_NONE;
  logic                running      = 1'b0;

  out_t        pending_results[$];
  int unsigned fail_count   = 0;
  int unsigned cycle_count  = 0;
  int unsigned ready_stall  = 0;
  int unsigned holdoff_req  = 0;
  int unsigned holdoff_done = 0;
  bit          calm         = 1'b0;

  // Directed script, run with simul_ticks 0 and hold_ticks 1, then hold_ticks 0.
  localparam int NumRows = 28;
  row_t script [NumRows] = '{
    '{ROW_SIMUL, 14'd0, '0, 1'b0, '0},
    '{ROW_HOLD, 14'd1, '0, 1'b0, '0},
    // Release, start/stop toggle and the set views.
    '{ROW_TICK, '0, {PAT_NONE, DMODE_DATA, VIEW_DIST}, 1'b1, {SIG_NONE, NoReq}},
    '{ROW_TICK, '0, {PAT_START, DMODE_DATA, VIEW_DIST}, 1'b1, {SIG_START, NoReq}},
    '{ROW_TICK, '0, {PAT_START, DMODE_UNITS, VIEW_TIME}, 1'b1, {SIG_STOP, NoReq}},
    '{ROW_TICK, '0, {PAT_SET, DMODE_DATA, VIEW_DIST}, 1'b1, {SIG_CALC_MODE, NoReq}},
    '{ROW_TICK, '0, {PAT_SET, DMODE_CIRC, VIEW_TIME}, 1'b1, {SIG_CALC_MODE, NoReq}},
    '{ROW_TICK, '0, {PAT_SET, DMODE_OTHER, VIEW_SPEED}, 1'b1, {SIG_TIRE_CIRC, NoReq}},
    '{ROW_TICK, '0, {PAT_SET, DMODE_DATA, VIEW_OTHER}, 1'b1, {SIG_SET, NoReq}},
    // Unused combinations repeat the last signal.
    '{ROW_TICK, '0, {PAT_MODE | PAT_SET, DMODE_DATA, VIEW_DIST}, 1'b0, '0},
    '{ROW_TICK, '0, {PAT_SET | PAT_START, DMODE_OTHER, VIEW_OTHER}, 1'b0, '0},
    // Mode changed early in units mode, then released.
    '{ROW_TICK, '0, {PAT_MODE, DMODE_UNITS, VIEW_DIST}, 1'b0, '0},
    '{ROW_TICK, '0, {PAT_NONE, DMODE_UNITS, VIEW_DIST}, 1'b0, '0},
    '{ROW_TICK, '0, {PAT_NONE, DMODE_DATA, VIEW_DIST}, 1'b0, '0},
    // Mode held to the timeout, then released.
    '{ROW_TICK, '0, {PAT_MODE, DMODE_OTHER, VIEW_SPEED}, 1'b0, '0},
    '{ROW_TICK, '0, {PAT_MODE, DMODE_OTHER, VIEW_SPEED}, 1'b0, '0},
    '{ROW_TICK, '0, {PAT_NONE, DMODE_DATA, VIEW_DIST}, 1'b0, '0},
    // Mode changed early in circumference mode.
    '{ROW_TICK, '0, {PAT_MODE, DMODE_CIRC, VIEW_DIST}, 1'b0, '0},
    '{ROW_TICK, '0, {PAT_MODE | PAT_SET, DMODE_CIRC, VIEW_DIST}, 1'b0, '0},
    // All three held.
    '{ROW_TICK, '0, {PAT_ALL, DMODE_DATA, VIEW_OTHER}, 1'b0, '0},
    '{ROW_TICK, '0, {PAT_ALL, DMODE_DATA, VIEW_OTHER}, 1'b0, '0},
    // Mode plus start/stop held in data mode asks for a trip reset.
    '{ROW_TICK, '0, {PAT_MODE_START, DMODE_DATA, VIEW_DIST}, 1'b0, '0},
    '{ROW_TICK, '0, {PAT_MODE_START, DMODE_DATA, VIEW_DIST}, 1'b0, '0},
    // Mode plus start/stop broken before the timeout.
    '{ROW_TICK, '0, {PAT_MODE_START, DMODE_UNITS, VIEW_TIME}, 1'b0, '0},
    '{ROW_TICK, '0, {PAT_START, DMODE_UNITS, VIEW_TIME}, 1'b0, '0},
    // Hold window already over when the sampling window closes.
    '{ROW_HOLD, 14'd0, '0, 1'b0, '0},
    '{ROW_TICK, '0, {PAT_MODE, DMODE_UNITS, VIEW_DIST}, 1'b0, '0},
    '{ROW_TICK, '0, {PAT_ALL, DMODE_DATA, VIEW_DIST}, 1'b0, '0}
  };

  button_gesture_classifier u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("%0t: run limit of %0d cycles reached", $time, CycleLimit);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Classifies one tick; returns 1 when the tick closes a classification.
  function automatic logic classify_tick(input in_t tick, output out_t res);
    res = '0;
    if (cls_phase == CLS_IDLE) begin
      elapsed = '0;
      cls_phase = CLS_WINDOW;
    end else if (elapsed != '1) begin
      elapsed = elapsed + 1'b1;
    end
    if (cls_phase == CLS_WINDOW) begin
      // The last sample of the window decides the pattern.
      held_pattern = tick.buttons;
      if (elapsed < ElapsedW'(cfg_simul)) return 1'b0;
      case (held_pattern)
        PAT_NONE: begin
          if (prev_signal == SIG_MODE || prev_signal == SIG_MODE_HELD)
            res.signal_code = SIG_MODE_REL;
          else
            res.signal_code = SIG_NONE;
        end
        PAT_SET: begin
          if (tick.display_view == VIEW_DIST || tick.display_view == VIEW_TIME)
            res.signal_code = SIG_CALC_MODE;
          else if (tick.display_view == VIEW_SPEED)
            res.signal_code = SIG_TIRE_CIRC;
          else
            res.signal_code = SIG_SET;
        end
        PAT_START: begin
          res.signal_code = running ? SIG_STOP : SIG_START;
          running = !running;
        end
        PAT_ALL, PAT_MODE_START, PAT_MODE: begin
          // A hold that can no longer be reached repeats the last signal.
          if (cfg_hold <= elapsed) begin
            res.signal_code = prev_signal;
          end else begin
            cls_phase = CLS_HOLD;
            return 1'b0;
          end
        end
        default: res.signal_code = prev_signal;
      endcase
    end else if (tick.buttons != held_pattern) begin
      // The buttons changed before the hold timed out.
      if (held_pattern == PAT_MODE) begin
        res.signal_code = SIG_MODE;
        res.toggle_units = (tick.display_mode == DMODE_UNITS);
        res.cycle_circumference = (tick.display_mode == DMODE_CIRC);
      end else begin
        res.signal_code = SIG_NONE;
      end
    end else if (elapsed < cfg_hold) begin
      return 1'b0;
    end else begin
      case (held_pattern)
        PAT_ALL:  res.signal_code = SIG_ALL_HELD;
        PAT_MODE: res.signal_code = SIG_MODE_HELD;
        default: begin
          res.signal_code = SIG_MS_HELD;
          res.reset_trip = (tick.display_mode == DMODE_DATA);
        end
      endcase
    end
    prev_signal = res.signal_code;
    cls_phase = CLS_IDLE;
    return 1'b1;
  endfunction

  function automatic in_t random_tick(input logic [BtnW-1:0] pat);
    in_t t;
    t.buttons = pat;
    t.display_mode = DispW'($urandom_range(0, 3));
    t.display_view = DispW'($urandom_range(0, 3));
    return t;
  endfunction

  task automatic compare_field(input string name, input logic [CodeW-1:0] want,
                               input logic [CodeW-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // One APB transfer: setup cycle, access cycle, then idle with psel low.
  task automatic apb_xfer(input logic wr, input logic idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_readback(input logic idx, input logic [31:0] want);
    logic [31:0] got;
    apb_xfer(1'b0, idx, '0, got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: register %0d readback mismatch, expected %0d, actual %0d",
               $time, idx, want, got);
    end
  endtask

  // Stops offering ticks until every expected result has been taken.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    logic [31:0] ignored_rdata;
    wait_idle();
    apb_xfer(1'b1, idx, value, ignored_rdata);
    if (idx == REG_SIMUL)
      cfg_simul = value[SimulW-1:0];
    else
      cfg_hold = value[HoldW-1:0];
    reg_readback(idx, value);
  endtask

  // Offers one tick, waits for the transaction, and records its expectation.
  // On return in_valid is still high; the caller lowers it or sends again.
  task automatic send_tick(input in_t tick, input logic typed, input out_t want,
                           output logic got_result);
    out_t res;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= tick;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got_result = classify_tick(tick, res);
    if (typed)
      pending_results.push_back(want);
    else if (got_result)
      pending_results.push_back(res);
  endtask

  // Random gestures under one register setting, then close the open
  // classification so the next setting starts from idle.
  task automatic run_phase(input int unsigned simul, input int unsigned hold,
                           input int unsigned budget, input bit squeeze, input bit pause);
    int unsigned     sent;
    int unsigned     span;
    int unsigned     len;
    logic [BtnW-1:0] pat;
    bit              noisy;
    logic            got;
    in_t             tick;
    write_reg(REG_SIMUL, simul);
    write_reg(REG_HOLD, hold);
    sent = 0;
    span = simul + hold + 2;
    while (sent < budget) begin
      // A gesture holds one pattern until a result or its length runs out;
      // a few gestures are broken up by random presses.
      pat = BtnW'($urandom_range(0, 7));
      noisy = ($urandom_range(0, 4) == 0);
      len = $urandom_range(0, 1) ? span : $urandom_range(1, span);
      got = 1'b0;
      for (int unsigned n = 0; n < len && !got; n++) begin
        if (noisy && $urandom_range(0, 3) == 0)
          tick = random_tick(BtnW'($urandom_range(0, 7)));
        else
          tick = random_tick(pat);
        if (squeeze && sent == budget / 2) holdoff_req <= holdoff_req + 1;
        if (pause && sent == budget / 2) wait_idle();
        send_tick(tick, 1'b0, '0, got);
        sent++;
      end
    end
    while (cls_phase != CLS_IDLE) begin
      send_tick(random_tick(BtnW'($urandom_range(0, 7))), 1'b0, '0, got);
    end
  endtask

  // Result receiver: random stall bursts, plus one long hold-off on request.
  always @(posedge clk) begin
    if (ready_stall > 0) begin
      ready_stall <= ready_stall - 1;
      out_ready <= 1'b0;
    end else if (holdoff_req != holdoff_done) begin
      holdoff_done <= holdoff_req;
      ready_stall <= 80;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      ready_stall <= $urandom_range(0, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result checker.
  always @(posedge clk) begin : check_results
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, actual code %0d",
                 $time, out_data.signal_code);
      end else begin
        want = pending_results.pop_front();
        compare_field("signal_code", want.signal_code, out_data.signal_code);
        compare_field("toggle_units", CodeW'(want.toggle_units),
                      CodeW'(out_data.toggle_units));
        compare_field("cycle_circumference", CodeW'(want.cycle_circumference),
                      CodeW'(out_data.cycle_circumference));
        compare_field("reset_trip", CodeW'(want.reset_trip), CodeW'(out_data.reset_trip));
      end
    end
  end

  // Main sequence.
  initial begin
    logic got;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers come out of reset at their documented values.
    reg_readback(REG_SIMUL, 32'(SIMUL_RESET));
    reg_readback(REG_HOLD, 32'(HOLD_RESET));

    // Directed script.
    foreach (script[i]) begin
      case (script[i].kind)
        ROW_SIMUL: write_reg(REG_SIMUL, 32'(script[i].value));
        ROW_HOLD:  write_reg(REG_HOLD, 32'(script[i].value));
        default:   send_tick(script[i].tick, script[i].typed, script[i].want, got);
      endcase
    end

    // Small settings carry most of the random traffic. Every tick gives a
    // result in the first one, so the long receiver hold-off backs up the input.
    run_phase(0, 0, 50, 1'b1, 1'b0);
    run_phase(0, 1, 50, 1'b0, 1'b0);
    run_phase(1, 3, 50, 1'b0, 1'b1);
    run_phase(3, 1, 40, 1'b0, 1'b0);
    run_phase(2, 6, 60, 1'b0, 1'b0);
    run_phase(0, 5, 50, 1'b0, 1'b0);
    run_phase($urandom_range(0, 4), $urandom_range(0, 12), 50, 1'b0, 1'b0);
    run_phase($urandom_range(0, 4), $urandom_range(0, 12), 50, 1'b0, 1'b0);

    // Register extremes, written and read back.
    write_reg(REG_SIMUL, 32'd4095);
    write_reg(REG_HOLD, 32'd16383);

    // Closing stretch at full rate on both sides.
    calm = 1'b1;
    run_phase(1, 4, 60, 1'b0, 1'b0);

    // Collect the last results.
    in_valid <= 1'b0;
    for (int i = 0; i < 2000 && pending_results.size() != 0; i++) @(posedge clk);
    if (pending_results.size() != 0) begin
      fail_count++;
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
    end
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
